// ===== rtl/pid_back_calculation_antiwindup_unit_defines.svh =====
// Assertion helpers for the PID unit. Each use sits inside a module that
// has clk and rst_n in scope.
`ifndef PID_BACK_CALCULATION_ANTIWINDUP_UNIT_DEFINES_SVH
`define PID_BACK_CALCULATION_ANTIWINDUP_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PBC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pbc_pkg.sv =====
package pbc_pkg;

  localparam int DataW        = 32;
  localparam int DtW          = 16;
  localparam int BetaW        = 17;
  localparam int CfgIdxW      = 3;
  localparam int MulW         = 33;
  localparam int ProdW        = 66;
  localparam int DivW         = 50;
  localparam int DivRadixBits = 2;

  localparam logic [BetaW-1:0] QOne      = 17'd65536;
  localparam logic [BetaW-1:0] BetaReset = 17'd61604;

  typedef logic signed [DataW-1:0] q_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP    = 3'd0,
    CFG_KI    = 3'd1,
    CFG_KD    = 3'd2,
    CFG_BETA  = 3'd3,
    CFG_LOWER = 3'd4,
    CFG_UPPER = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_ACC_I,
    ST_MUL_KI,
    ST_KI_WB,
    ST_DIV_WAIT,
    ST_MUL_B1,
    ST_MUL_B2,
    ST_FD_WB,
    ST_MUL_D,
    ST_SUM1,
    ST_SUM2,
    ST_SUM3,
    ST_CORR,
    ST_CORR_WAIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Saturate a wide signed value to the Q16.16 range.
  function automatic q_t sat32(input logic signed [ProdW-1:0] x);
    if (x[ProdW-1:DataW-1] == '0 || x[ProdW-1:DataW-1] == '1) begin
      return x[DataW-1:0];
    end else if (x[ProdW-1]) begin
      return {1'b1, {(DataW-1){1'b0}}};
    end else begin
      return {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

  // When the bounds are crossed, values below lo return lo and all others return hi.
  function automatic q_t clampb(input q_t x, input q_t lo, input q_t hi);
    if (x < lo) begin
      return lo;
    end else if (x > hi) begin
      return hi;
    end else begin
      return x;
    end
  endfunction

endpackage

// ===== rtl/pbc_intf.sv =====
interface pbc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic signed [pbc_pkg::DataW-1:0]      error_in;
  logic        [pbc_pkg::DtW-1:0]        dt;

  modport source (output valid, kind, error_in, dt, input ready);
  modport sink   (input valid, kind, error_in, dt, output ready);
endinterface

interface pbc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pbc_pkg::DataW-1:0]      drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface pbc_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic        [pbc_pkg::CfgIdxW-1:0]    index;
  logic        [pbc_pkg::DataW-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pbc_mul.sv =====
module pbc_mul (
  input  logic                               clk,
  input  logic signed [pbc_pkg::MulW-1:0]    mul_a,
  input  logic signed [pbc_pkg::MulW-1:0]    mul_b,
  output logic signed [pbc_pkg::ProdW-1:0]   prod
);

  logic signed [pbc_pkg::ProdW-1:0] prod_r;
  logic signed [pbc_pkg::ProdW-1:0] prod_nxt;

  assign prod_nxt = pbc_pkg::ProdW'(mul_a) * pbc_pkg::ProdW'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// ===== rtl/pbc_div.sv =====
module pbc_div #(
  parameter int BITS_PER_STEP = pbc_pkg::DivRadixBits
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [pbc_pkg::DivW-1:0]    dividend,
  input  logic signed [pbc_pkg::DataW-1:0]   divisor,
  output pbc_pkg::div_stat_t                 stat,
  output logic signed [pbc_pkg::DivW-1:0]    quotient
);

  localparam int DivW  = pbc_pkg::DivW;
  localparam int RemW  = pbc_pkg::DataW + 1;
  localparam int Steps = (DivW + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int QW    = Steps * BITS_PER_STEP;
  localparam int CntW  = $clog2(Steps + 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CntW-1:0]            cnt_r, cnt_nxt;
  logic [RemW-1:0]            rem_r, rem_nxt;
  logic [QW-1:0]              quo_r, quo_nxt;
  logic [pbc_pkg::DataW-1:0]  dvs_r, dvs_nxt;
  logic                       neg_r, neg_nxt;

  logic [RemW-1:0]            rem_v;
  logic [QW-1:0]              quo_v;
  logic [DivW-1:0]            dnd_mag;
  logic signed [DivW-1:0]     dnd_neg;
  logic signed [pbc_pkg::DataW-1:0] dvs_neg;
  logic signed [DivW-1:0]     qmag;

  assign dnd_neg = -dividend;
  assign dvs_neg = -divisor;
  assign dnd_mag = dividend[DivW-1] ? dnd_neg : dividend;

  // Restoring steps: shift in dividend bits, subtract where it fits.
  always_comb begin
    rem_v = rem_r;
    quo_v = quo_r;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      rem_v = {rem_v[RemW-2:0], quo_v[QW-1]};
      quo_v = {quo_v[QW-2:0], 1'b0};
      if (rem_v >= {1'b0, dvs_r}) begin
        rem_v    = rem_v - {1'b0, dvs_r};
        quo_v[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = QW'(dnd_mag);
      dvs_nxt  = divisor[pbc_pkg::DataW-1] ? dvs_neg : divisor;
      neg_nxt  = dividend[DivW-1] ^ divisor[pbc_pkg::DataW-1];
    end else if (busy_r) begin
      rem_nxt = rem_v;
      quo_nxt = quo_v;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(Steps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // Quotient magnitude stays below 2^49, so the sign bit of the slice is zero.
  assign qmag      = quo_r[DivW-1:0];
  assign quotient  = neg_r ? -qmag : qmag;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/pid_back_calculation_antiwindup_unit.sv =====
// PID controller with back-calculation anti-windup, signed Q16.16 throughout.
// A control sample (kind 0) computes P = kp*e, a trapezoidal integral
// I += (prev_e + e)*dt/2, and a filtered derivative
// D = beta*D + (1-beta)*(e - prev_e)/dt; the output is
// clamp(clamp(P + clamp(kd*D)) + ki*I), and when ki is nonzero the
// saturation excess divided by ki is fed back into the integral. A clear
// transaction (kind 1) zeroes the integral and returns the last drive.
// A control sample makes two passes through the shared radix-2^B divider,
// where B is DIV_BITS_PER_STEP (rate by dt, then the correction by ki),
// while the six products share one registered 33x33 multiplier. With ki
// zero the second pass is skipped. in_ch.ready is high only between
// transactions; the result sits in an output register, so the next input
// may be taken while the previous result waits on out_ch.ready.
// Configuration writes are taken every cycle (cfg_ch.ready is tied high) and
// must only be issued while the unit is idle. Intermediate values saturate.
`include "pid_back_calculation_antiwindup_unit_defines.svh"

module pid_back_calculation_antiwindup_unit #(
  parameter int DIV_BITS_PER_STEP = pbc_pkg::DivRadixBits
) (
  input  logic          clk,
  input  logic          rst_n,
  pbc_cfg_if.sink       cfg_ch,
  pbc_in_if.sink        in_ch,
  pbc_out_if.source     out_ch
);

  localparam int DataW = pbc_pkg::DataW;
  localparam int MulW  = pbc_pkg::MulW;
  localparam int ProdW = pbc_pkg::ProdW;
  localparam int DivW  = pbc_pkg::DivW;
  localparam int BetaW = pbc_pkg::BetaW;
  localparam int DtW   = pbc_pkg::DtW;

  // Control state
  pbc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Configuration registers
  pbc_pkg::q_t        kp_r, kp_nxt;
  pbc_pkg::q_t        ki_r, ki_nxt;
  pbc_pkg::q_t        kd_r, kd_nxt;
  logic [BetaW-1:0]   beta_r, beta_nxt;
  pbc_pkg::q_t        lower_r, lower_nxt;
  pbc_pkg::q_t        upper_r, upper_nxt;

  // Controller state carried between transactions
  pbc_pkg::q_t        prev_r, prev_nxt;
  pbc_pkg::q_t        integ_r, integ_nxt;
  pbc_pkg::q_t        fd_r, fd_nxt;
  pbc_pkg::q_t        last_r, last_nxt;

  // Per-transaction working registers
  pbc_pkg::q_t        e_r, e_nxt;
  logic [DtW-1:0]     dt_r, dt_nxt;
  pbc_pkg::q_t        pout_r, pout_nxt;
  pbc_pkg::q_t        iout_r, iout_nxt;
  pbc_pkg::q_t        rate_r, rate_nxt;
  logic signed [ProdW-1:0] acc_r, acc_nxt;
  pbc_pkg::q_t        dterm_r, dterm_nxt;
  pbc_pkg::q_t        pd_r, pd_nxt;
  pbc_pkg::q_t        uns_r, uns_nxt;
  pbc_pkg::q_t        drive_r, drive_nxt;
  pbc_pkg::q_t        res_r, res_nxt;
  pbc_pkg::q_t        out_drive_r, out_drive_nxt;

  // Shared units
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  prod;
  logic                     div_start;
  logic signed [DivW-1:0]   div_dividend;
  pbc_pkg::q_t              div_divisor;
  pbc_pkg::div_stat_t       div_stat;
  logic signed [DivW-1:0]   div_quot;

  // Helpers
  logic                     in_fire;
  logic                     out_free;
  logic [BetaW-1:0]         beta_c;
  logic [BetaW-1:0]         one_minus_beta;
  logic signed [MulW-1:0]   err_diff;
  logic signed [MulW-1:0]   sat_diff;
  pbc_pkg::q_t              uns_v;
  pbc_pkg::q_t              drive_v;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign beta_c         = (beta_r > pbc_pkg::QOne) ? pbc_pkg::QOne : beta_r;
  assign one_minus_beta = pbc_pkg::QOne - beta_c;
  assign err_diff       = MulW'(e_r) - MulW'(prev_r);
  assign sat_diff       = MulW'(drive_r) - MulW'(uns_r);

  assign uns_v   = pbc_pkg::sat32(ProdW'(pd_r) + ProdW'(iout_r));
  assign drive_v = pbc_pkg::clampb(uns_v, lower_r, upper_r);

  pbc_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  pbc_div #(
    .BITS_PER_STEP (DIV_BITS_PER_STEP)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pbc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = in_ch.kind ? pbc_pkg::ST_CORR_WAIT : pbc_pkg::ST_MUL_P;
        end
      end
      pbc_pkg::ST_MUL_P:    state_nxt = pbc_pkg::ST_MUL_I;
      pbc_pkg::ST_MUL_I:    state_nxt = pbc_pkg::ST_ACC_I;
      pbc_pkg::ST_ACC_I:    state_nxt = pbc_pkg::ST_MUL_KI;
      pbc_pkg::ST_MUL_KI:   state_nxt = pbc_pkg::ST_KI_WB;
      pbc_pkg::ST_KI_WB:    state_nxt = pbc_pkg::ST_DIV_WAIT;
      pbc_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = pbc_pkg::ST_MUL_B1;
        end
      end
      pbc_pkg::ST_MUL_B1:   state_nxt = pbc_pkg::ST_MUL_B2;
      pbc_pkg::ST_MUL_B2:   state_nxt = pbc_pkg::ST_FD_WB;
      pbc_pkg::ST_FD_WB:    state_nxt = pbc_pkg::ST_MUL_D;
      pbc_pkg::ST_MUL_D:    state_nxt = pbc_pkg::ST_SUM1;
      pbc_pkg::ST_SUM1:     state_nxt = pbc_pkg::ST_SUM2;
      pbc_pkg::ST_SUM2:     state_nxt = pbc_pkg::ST_SUM3;
      pbc_pkg::ST_SUM3: begin
        // ki of zero skips back-calculation; park in the wait state with
        // the divider idle so the result is handed over from there.
        state_nxt = (ki_r != '0) ? pbc_pkg::ST_CORR : pbc_pkg::ST_CORR_WAIT;
      end
      pbc_pkg::ST_CORR:     state_nxt = pbc_pkg::ST_CORR_WAIT;
      pbc_pkg::ST_CORR_WAIT: begin
        // Clear transactions and ki-zero samples hand over once the output is
        // free; a correction first waits for its quotient to be added in.
        if (!div_stat.busy && !div_stat.done && out_free) begin
          state_nxt = pbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pbc_pkg::ST_IDLE;
    endcase
  end

  // Datapath, unit operands and handshake outputs
  always_comb begin
    kp_nxt        = kp_r;
    ki_nxt        = ki_r;
    kd_nxt        = kd_r;
    beta_nxt      = beta_r;
    lower_nxt     = lower_r;
    upper_nxt     = upper_r;
    prev_nxt      = prev_r;
    integ_nxt     = integ_r;
    fd_nxt        = fd_r;
    last_nxt      = last_r;
    e_nxt         = e_r;
    dt_nxt        = dt_r;
    pout_nxt      = pout_r;
    iout_nxt      = iout_r;
    rate_nxt      = rate_r;
    acc_nxt       = acc_r;
    dterm_nxt     = dterm_r;
    pd_nxt        = pd_r;
    uns_nxt       = uns_r;
    drive_nxt     = drive_r;
    res_nxt       = res_r;
    out_drive_nxt = out_drive_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_dividend  = DivW'(err_diff) <<< 16;
    div_divisor   = $signed({{(DataW-DtW){1'b0}}, dt_r});

    // Register writes; indexes past the list are dropped.
    if (cfg_ch.valid) begin
      case (pbc_pkg::cfg_idx_t'(cfg_ch.index))
        pbc_pkg::CFG_KP:    kp_nxt    = cfg_ch.data;
        pbc_pkg::CFG_KI:    ki_nxt    = cfg_ch.data;
        pbc_pkg::CFG_KD:    kd_nxt    = cfg_ch.data;
        pbc_pkg::CFG_BETA:  beta_nxt  = cfg_ch.data[BetaW-1:0];
        pbc_pkg::CFG_LOWER: lower_nxt = cfg_ch.data;
        pbc_pkg::CFG_UPPER: upper_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    case (state_r)
      pbc_pkg::ST_IDLE: begin
        if (in_fire) begin
          e_nxt  = in_ch.error_in;
          dt_nxt = in_ch.dt;
          if (in_ch.kind) begin
            integ_nxt = '0;
            res_nxt   = last_r;
          end
        end
      end
      pbc_pkg::ST_MUL_P: begin
        mul_a = MulW'(kp_r);
        mul_b = MulW'(e_r);
      end
      pbc_pkg::ST_MUL_I: begin
        pout_nxt = pbc_pkg::sat32(prod >>> 16);
        mul_a    = MulW'(e_r) + MulW'(prev_r);
        mul_b    = MulW'($signed({1'b0, dt_r}));
      end
      pbc_pkg::ST_ACC_I: begin
        // Trapezoid increment: (prev + e)*dt/2, floored.
        integ_nxt = pbc_pkg::sat32(ProdW'(integ_r) + (prod >>> 17));
        div_start = 1'b1;
      end
      pbc_pkg::ST_MUL_KI: begin
        mul_a = MulW'(ki_r);
        mul_b = MulW'(integ_r);
      end
      pbc_pkg::ST_KI_WB: begin
        iout_nxt = pbc_pkg::sat32(prod >>> 16);
      end
      pbc_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          rate_nxt = (dt_r == '0) ? '0 : pbc_pkg::sat32(ProdW'(div_quot));
        end
      end
      pbc_pkg::ST_MUL_B1: begin
        mul_a = MulW'($signed({1'b0, beta_c}));
        mul_b = MulW'(fd_r);
      end
      pbc_pkg::ST_MUL_B2: begin
        acc_nxt = prod;
        mul_a   = MulW'($signed({1'b0, one_minus_beta}));
        mul_b   = MulW'(rate_r);
      end
      pbc_pkg::ST_FD_WB: begin
        fd_nxt = pbc_pkg::sat32((acc_r + prod) >>> 16);
      end
      pbc_pkg::ST_MUL_D: begin
        mul_a = MulW'(fd_r);
        mul_b = MulW'(kd_r);
      end
      pbc_pkg::ST_SUM1: begin
        dterm_nxt = pbc_pkg::clampb(pbc_pkg::sat32(prod >>> 16), lower_r, upper_r);
      end
      pbc_pkg::ST_SUM2: begin
        pd_nxt = pbc_pkg::clampb(pbc_pkg::sat32(ProdW'(pout_r) + ProdW'(dterm_r)),
                                 lower_r, upper_r);
      end
      pbc_pkg::ST_SUM3: begin
        uns_nxt   = uns_v;
        drive_nxt = drive_v;
        res_nxt   = drive_v;
        last_nxt  = drive_v;
        prev_nxt  = e_r;
      end
      pbc_pkg::ST_CORR: begin
        // Excess (drive - unsaturated) scaled by 1/ki, truncated toward zero.
        div_dividend = DivW'(sat_diff) <<< 16;
        div_divisor  = ki_r;
        div_start    = 1'b1;
      end
      pbc_pkg::ST_CORR_WAIT: begin
        if (div_stat.done) begin
          integ_nxt = pbc_pkg::sat32(ProdW'(integ_r) + ProdW'(div_quot));
        end
        if (!div_stat.busy && !div_stat.done && out_free) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      beta_r      <= pbc_pkg::BetaReset;
      lower_r     <= {1'b1, {(DataW-1){1'b0}}};
      upper_r     <= {1'b0, {(DataW-1){1'b1}}};
      prev_r      <= '0;
      integ_r     <= '0;
      fd_r        <= '0;
      last_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      kp_r        <= kp_nxt;
      ki_r        <= ki_nxt;
      kd_r        <= kd_nxt;
      beta_r      <= beta_nxt;
      lower_r     <= lower_nxt;
      upper_r     <= upper_nxt;
      prev_r      <= prev_nxt;
      integ_r     <= integ_nxt;
      fd_r        <= fd_nxt;
      last_r      <= last_nxt;
    end
  end

  // Working registers hold payload only; no reset.
  always_ff @(posedge clk) begin
    e_r         <= e_nxt;
    dt_r        <= dt_nxt;
    pout_r      <= pout_nxt;
    iout_r      <= iout_nxt;
    rate_r      <= rate_nxt;
    acc_r       <= acc_nxt;
    dterm_r     <= dterm_nxt;
    pd_r        <= pd_nxt;
    uns_r       <= uns_nxt;
    drive_r     <= drive_nxt;
    res_r       <= res_nxt;
    out_drive_r <= out_drive_nxt;
  end

  assign in_ch.ready  = (state_r == pbc_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = out_drive_r;

  `PBC_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `PBC_ASSERT_NEXT(a_clear_zeroes_integ, in_fire && in_ch.kind, integ_r == '0, "clear left integral nonzero")
  `PBC_ASSERT_SAME(a_corr_needs_ki, state_r == pbc_pkg::ST_CORR, ki_r != '0, "back-calculation with ki zero")
  `PBC_ASSERT_NEXT(a_drive_in_bounds, state_r == pbc_pkg::ST_SUM3 && lower_r <= upper_r, drive_r >= lower_r && drive_r <= upper_r, "drive outside bounds")

endmodule
